>>> rtl/core/v3pr_pkg.sv
`default_nettype none
package v3pr_pkg;

    // quotient bits needed: |t| < 2^34 for any nonzero direction
    localparam int QBITS = 35;
    localparam int NUM_W = 97;

    // pipeline stage indices
    localparam int ST_PROD = 0;
    localparam int ST_SUM  = 1;
    localparam int ST_MAG  = 2;
    localparam int ST_PART = 3;
    localparam int ST_NUM  = 4;
    localparam int ST_DIV0 = 5;
    localparam int ST_OUT  = ST_DIV0 + QBITS;
    localparam int NSTG    = ST_OUT + 1;
    localparam int LANE_STG = NSTG - ST_PART;

    localparam logic [1:0] CMD_PROJECT = 2'd0;
    localparam logic [1:0] CMD_REJECT  = 2'd1;
    localparam logic [1:0] CMD_REFLECT = 2'd2;
    localparam logic [1:0] CMD_MIRROR  = 2'd3;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } req_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               ok;
    } rsp_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       dneg;
        logic       nz;
    } ctrl_t;

endpackage
`default_nettype wire

>>> rtl/core/v3pr_prod_lane.sv
`default_nettype none
module v3pr_prod_lane (
    input  logic               clk,
    input  logic [2:0]         en,
    input  logic signed [31:0] vec,
    input  logic signed [31:0] dir,
    output logic [63:0]        vd_reg,
    output logic [63:0]        dd_reg,
    output logic               opp_reg,
    output logic signed [31:0] vec_out,
    output logic [31:0]        dabs_out,
    output logic               dsign_out
);

    logic [31:0]        vabs;
    logic [31:0]        dabs;
    logic signed [31:0] vec_reg   [3];
    logic [31:0]        dabs_reg  [3];
    logic               dsign_reg [3];

    assign vabs = vec[31] ? (~vec + 32'd1) : vec;
    assign dabs = dir[31] ? (~dir + 32'd1) : dir;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            vd_reg       <= vabs * dabs;
            dd_reg       <= dabs * dabs;
            opp_reg      <= vec[31] ^ dir[31];
            vec_reg[0]   <= vec;
            dabs_reg[0]  <= dabs;
            dsign_reg[0] <= dir[31];
        end
        if (en[1])
        begin
            vec_reg[1]   <= vec_reg[0];
            dabs_reg[1]  <= dabs_reg[0];
            dsign_reg[1] <= dsign_reg[0];
        end
        if (en[2])
        begin
            vec_reg[2]   <= vec_reg[1];
            dabs_reg[2]  <= dabs_reg[1];
            dsign_reg[2] <= dsign_reg[1];
        end
    end

    assign vec_out   = vec_reg[2];
    assign dabs_out  = dabs_reg[2];
    assign dsign_out = dsign_reg[2];

endmodule
`default_nettype wire

>>> rtl/core/v3pr_div_lane.sv
`default_nettype none
module v3pr_div_lane (
    input  logic                         clk,
    input  logic [v3pr_pkg::LANE_STG-1:0] en,
    input  v3pr_pkg::ctrl_t              ctrl_in,
    input  logic [63:0]                  n_in,
    input  logic [63:0]                  dmag_in,
    input  logic signed [31:0]           vec_in,
    input  logic [31:0]                  dabs_in,
    input  logic                         dsign_in,
    output logic signed [31:0]           res_reg,
    output v3pr_pkg::ctrl_t              ctrl_out
);

    localparam int QB = v3pr_pkg::QBITS;

    // partial product stage
    logic [63:0]        p0_reg;
    logic [63:0]        p1_reg;
    v3pr_pkg::ctrl_t    ctrl_p_reg;
    logic [63:0]        n_p_reg;
    logic signed [31:0] vec_p_reg;
    logic               dsign_p_reg;

    // divider stages, index 0 holds the loaded numerator
    logic [63:0]        rem_reg   [QB+1];
    logic [QB-1:0]      low_reg   [QB+1];
    logic [QB-1:0]      q_reg     [QB+1];
    logic [63:0]        n_reg     [QB+1];
    v3pr_pkg::ctrl_t    ctrl_reg  [QB+1];
    logic signed [31:0] vec_reg   [QB+1];
    logic               dsign_reg [QB+1];

    logic [95:0]        prod;
    logic [v3pr_pkg::NUM_W-1:0] num;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p0_reg      <= dmag_in[31:0] * dabs_in;
            p1_reg      <= dmag_in[63:32] * dabs_in;
            ctrl_p_reg  <= ctrl_in;
            n_p_reg     <= n_in;
            vec_p_reg   <= vec_in;
            dsign_p_reg <= dsign_in;
        end
    end

    assign prod = {32'd0, p0_reg} + {p1_reg, 32'd0};
    // reflect and mirror double the term
    assign num  = ctrl_p_reg.cmd[1] ? {prod, 1'b0} : {1'b0, prod};

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            rem_reg[0]   <= 64'(num[v3pr_pkg::NUM_W-1:QB]);
            low_reg[0]   <= num[QB-1:0];
            q_reg[0]     <= '0;
            n_reg[0]     <= n_p_reg;
            ctrl_reg[0]  <= ctrl_p_reg;
            vec_reg[0]   <= vec_p_reg;
            dsign_reg[0] <= dsign_p_reg;
        end
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_step
        logic [64:0] trial;
        logic [64:0] diff;
        logic        ge;

        assign trial = {rem_reg[k], low_reg[k][QB-1]};
        assign diff  = trial - {1'b0, n_reg[k]};
        assign ge    = trial >= {1'b0, n_reg[k]};

        always_ff @(posedge clk)
        begin
            if (en[2+k])
            begin
                rem_reg[k+1]   <= ge ? diff[63:0] : trial[63:0];
                low_reg[k+1]   <= {low_reg[k][QB-2:0], 1'b0};
                q_reg[k+1]     <= {q_reg[k][QB-2:0], ge};
                n_reg[k+1]     <= n_reg[k];
                ctrl_reg[k+1]  <= ctrl_reg[k];
                vec_reg[k+1]   <= vec_reg[k];
                dsign_reg[k+1] <= dsign_reg[k];
            end
        end
    end

    logic [QB:0]        tmag;
    logic signed [QB:0] t;
    logic signed [QB+1:0] r;
    logic signed [QB+1:0] vext;
    logic signed [31:0] sat;

    assign tmag = {1'b0, q_reg[QB]};
    assign t    = (ctrl_reg[QB].dneg != dsign_reg[QB]) ? -$signed(tmag) : $signed(tmag);
    assign vext = (QB+2)'(vec_reg[QB]);

    always_comb
    begin
        unique case (ctrl_reg[QB].cmd)
            v3pr_pkg::CMD_PROJECT: r = (QB+2)'(t);
            v3pr_pkg::CMD_MIRROR:  r = (QB+2)'(t) - vext;
            v3pr_pkg::CMD_REJECT:  r = vext - (QB+2)'(t);
            v3pr_pkg::CMD_REFLECT: r = vext - (QB+2)'(t);
        endcase
        if (!ctrl_reg[QB].nz)
            sat = '0;
        else if (r > (QB+2)'(64'sd2147483647))
            sat = 32'sh7fffffff;
        else if (r < -(QB+2)'(64'sd2147483648))
            sat = 32'sh80000000;
        else
            sat = r[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[2+QB])
        begin
            res_reg  <= sat;
            ctrl_out <= ctrl_reg[QB];
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/vector3_project_reflect_unit.sv
// depth: 41 register stages from req acceptance to rsp valid
// throughput: one item per cycle unless rsp_ready stalls; each axis lane runs a
// 35-stage restoring divider, one quotient bit per stage, which sets the pipeline depth
// stages with no item close up, so req is taken while a rsp waits if any stage is empty
// reset: asynchronous active-low rst_n clears stage valid bits only
`default_nettype none
module vector3_project_reflect_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  v3pr_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output v3pr_pkg::rsp_t rsp
);

    localparam int NS = v3pr_pkg::NSTG;

    // stage occupancy and advance
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS-1:0] en;

    always_comb
    begin
        en[NS-1] = !vld_reg[NS-1] || rsp_ready;
        for (int i = NS - 2; i >= 0; i--)
            en[i] = !vld_reg[i] || en[i+1];
        vld_next[0] = en[0] ? req_valid : vld_reg[0];
        for (int i = 1; i < NS; i++)
            vld_next[i] = en[i] ? vld_reg[i-1] : vld_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign req_ready = en[0];
    assign rsp_valid = vld_reg[NS-1];

    // per-axis product lanes
    logic signed [31:0] vec_in   [3];
    logic signed [31:0] dir_in   [3];
    logic [63:0]        vd       [3];
    logic [63:0]        dd       [3];
    logic               opp      [3];
    logic signed [31:0] vec_d    [3];
    logic [31:0]        dabs_d   [3];
    logic               dsign_d  [3];

    assign vec_in[0] = req.vec_x;
    assign vec_in[1] = req.vec_y;
    assign vec_in[2] = req.vec_z;
    assign dir_in[0] = req.dir_x;
    assign dir_in[1] = req.dir_y;
    assign dir_in[2] = req.dir_z;

    for (genvar a = 0; a < 3; a++)
    begin : g_prod
        v3pr_prod_lane u_prod (
            .clk       (clk),
            .en        (en[v3pr_pkg::ST_MAG:v3pr_pkg::ST_PROD]),
            .vec       (vec_in[a]),
            .dir       (dir_in[a]),
            .vd_reg    (vd[a]),
            .dd_reg    (dd[a]),
            .opp_reg   (opp[a]),
            .vec_out   (vec_d[a]),
            .dabs_out  (dabs_d[a]),
            .dsign_out (dsign_d[a])
        );
    end

    // merge: dot product as positive and negative sums, squared length
    logic [1:0]  cmd_reg [3];
    logic [63:0] pos_reg;
    logic [63:0] neg_reg;
    logic [63:0] n_reg;
    logic [63:0] n_m_reg;
    logic [63:0] dmag_reg;
    logic        dneg_reg;
    logic        nz_reg;

    always_ff @(posedge clk)
    begin
        if (en[v3pr_pkg::ST_PROD])
            cmd_reg[0] <= req.cmd;
        if (en[v3pr_pkg::ST_SUM])
        begin
            cmd_reg[1] <= cmd_reg[0];
            pos_reg    <= (opp[0] ? 64'd0 : vd[0]) + (opp[1] ? 64'd0 : vd[1])
                        + (opp[2] ? 64'd0 : vd[2]);
            neg_reg    <= (opp[0] ? vd[0] : 64'd0) + (opp[1] ? vd[1] : 64'd0)
                        + (opp[2] ? vd[2] : 64'd0);
            n_reg      <= dd[0] + dd[1] + dd[2];
        end
        if (en[v3pr_pkg::ST_MAG])
        begin
            cmd_reg[2] <= cmd_reg[1];
            dneg_reg   <= neg_reg > pos_reg;
            dmag_reg   <= (neg_reg > pos_reg) ? neg_reg - pos_reg : pos_reg - neg_reg;
            nz_reg     <= n_reg != 64'd0;
            n_m_reg    <= n_reg;
        end
    end

    v3pr_pkg::ctrl_t ctrl_m;
    assign ctrl_m = '{cmd: cmd_reg[2], dneg: dneg_reg, nz: nz_reg};

    // per-axis scale and divide lanes
    logic signed [31:0] res   [3];
    v3pr_pkg::ctrl_t    ctrl_o [3];

    for (genvar a = 0; a < 3; a++)
    begin : g_div
        v3pr_div_lane u_div (
            .clk      (clk),
            .en       (en[v3pr_pkg::ST_OUT:v3pr_pkg::ST_PART]),
            .ctrl_in  (ctrl_m),
            .n_in     (n_m_reg),
            .dmag_in  (dmag_reg),
            .vec_in   (vec_d[a]),
            .dabs_in  (dabs_d[a]),
            .dsign_in (dsign_d[a]),
            .res_reg  (res[a]),
            .ctrl_out (ctrl_o[a])
        );
    end

    assign rsp.out_x = res[0];
    assign rsp.out_y = res[1];
    assign rsp.out_z = res[2];
    assign rsp.ok    = ctrl_o[0].nz & ctrl_o[1].nz & ctrl_o[2].nz;

`ifndef SYNTHESIS
    // a zero direction must give zero components
    a_zero_dir: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.ok |-> rsp.out_x == 32'sd0 && rsp.out_y == 32'sd0
            && rsp.out_z == 32'sd0)
        else $error("nonzero result for zero direction");

    // an empty first stage always takes an item
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[0] |-> req_ready)
        else $error("req stalled with empty first stage");

    // an accepted item occupies the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> vld_reg[0])
        else $error("accepted item lost");

    // a waiting rsp never blocks a pipe with a bubble in front
    a_bubble_fill: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NS-1] && !rsp_ready && !vld_reg[NS-2] |-> en[NS-2])
        else $error("bubble not collapsed");
`endif

endmodule
`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import v3pr_pkg::*;

    // expected-result store and checker for the projection unit
    class proj_scoreboard;
        rsp_t pending[$];
        int   errors;

        function new();
            errors = 0;
        endfunction

        // exact model of the unit: dot and |dir|^2 kept wide, one truncating divide
        function rsp_t compute(req_t r);
            logic signed [31:0] v[3];
            logic signed [31:0] d[3];
            logic signed [67:0] dot;
            logic [67:0]        nsq;
            logic signed [135:0] num;
            logic signed [135:0] quo;
            logic signed [67:0] t;
            logic signed [67:0] res;
            logic signed [31:0] o[3];
            rsp_t               p;
            v = '{r.vec_x, r.vec_y, r.vec_z};
            d = '{r.dir_x, r.dir_y, r.dir_z};
            dot = 0;
            nsq = 0;
            for (int i = 0; i < 3; i++)
            begin
                dot = dot + 68'(signed'(v[i])) * 68'(signed'(d[i]));
                nsq = nsq + 68'($signed(68'(signed'(d[i]))) * $signed(68'(signed'(d[i]))));
            end
            if (nsq == 0)
            begin
                p = '0;
                return p;
            end
            for (int i = 0; i < 3; i++)
            begin
                num = 136'(signed'(dot)) * 136'(signed'(d[i]));
                if (r.cmd == CMD_REFLECT || r.cmd == CMD_MIRROR)
                    num = num * 2;
                // signed division truncates toward zero
                quo = num / $signed({68'd0, nsq});
                t = quo[67:0];
                case (r.cmd)
                    CMD_PROJECT: res = t;
                    CMD_MIRROR:  res = t - 68'(signed'(v[i]));
                    default:     res = 68'(signed'(v[i])) - t;
                endcase
                if (res > 68'sd2147483647)
                    o[i] = 32'h7fffffff;
                else if (res < -68'sd2147483648)
                    o[i] = 32'h80000000;
                else
                    o[i] = res[31:0];
            end
            p.out_x = o[0];
            p.out_y = o[1];
            p.out_z = o[2];
            p.ok    = 1'b1;
            return p;
        endfunction

        function void note_request(req_t r);
            pending.push_back(compute(r));
        endfunction

        function void check_result(rsp_t a);
            rsp_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result %h", a);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.out_x !== e.out_x)
            begin
                $error("out_x expected %h actual %h", e.out_x, a.out_x);
                errors++;
            end
            if (a.out_y !== e.out_y)
            begin
                $error("out_y expected %h actual %h", e.out_y, a.out_y);
                errors++;
            end
            if (a.out_z !== e.out_z)
            begin
                $error("out_z expected %h actual %h", e.out_z, a.out_z);
                errors++;
            end
            if (a.ok !== e.ok)
            begin
                $error("ok expected %b actual %b", e.ok, a.ok);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    proj_scoreboard sb;
    int   gap_left;
    int   stall_mode;

    vector3_project_reflect_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // random component: mostly small values, some extremes, some full range
    function automatic logic [31:0] pick_comp();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3, 4: return $urandom();
            5: return 32'(signed'($urandom_range(0, 4)) - 2) << 16;
            default: return 32'(signed'($urandom_range(0, 32'h1ffff)) - 32'sh10000) << $urandom_range(0, 14);
        endcase
    endfunction

    // send one item; valid stays high until accepted, and is left high
    task automatic send_item(req_t r);
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sb.note_request(r);
    endtask

    // drop valid and wait the given number of cycles
    task automatic idle_cycles(int n);
        if (n > 0)
        begin
            req_valid <= 1'b0;
            repeat (n)
                @(posedge clk);
        end
    endtask

    // bursty sender: gaps between bursts of random length
    task automatic send_random(req_t r);
        if (gap_left == 0)
        begin
            gap_left = $urandom_range(1, 30);
            idle_cycles($urandom_range(0, 4));
        end
        gap_left--;
        send_item(r);
    endtask

    function automatic req_t make_req(logic [1:0] c, logic [31:0] vx, logic [31:0] vy,
                                      logic [31:0] vz, logic [31:0] dx, logic [31:0] dy,
                                      logic [31:0] dz);
        req_t r;
        r.cmd = c;
        r.vec_x = vx; r.vec_y = vy; r.vec_z = vz;
        r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
        return r;
    endfunction

    // receiver stall pattern: switches between no stall, light and heavy
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready  <= 1'b0;
            stall_mode <= 0;
        end
        else
        begin
            if ($urandom_range(0, 199) == 0)
                stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: rsp_ready <= 1'b1;
                1: rsp_ready <= ($urandom_range(0, 3) != 0);
                default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // check every accepted result
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_result(rsp);
    end

    initial
    begin
        req_t r;
        sb        = new();
        gap_left  = 0;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every op, zero direction, extremes, saturation
        for (int c = 0; c < 4; c++)
        begin
            send_item(make_req(2'(c), 32'h00010000, 32'h00020000, 32'hfffd0000,
                               32'h00010000, 32'h0, 32'h0));
            send_item(make_req(2'(c), 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                               32'h0, 32'h0, 32'h0));
            send_item(make_req(2'(c), 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                               32'h80000000, 32'h80000000, 32'h80000000));
            send_item(make_req(2'(c), 32'h80000000, 32'h7fffffff, 32'h80000000,
                               32'h00000001, 32'h7fffffff, 32'hffffffff));
            send_item(make_req(2'(c), 32'h80000000, 32'h80000000, 32'h80000000,
                               32'h00000001, 32'h0, 32'h0));
        end
        send_item(make_req(CMD_REFLECT, 32'hffffffff, 32'h1, 32'h0,
                           32'h7fffffff, 32'h80000000, 32'h1));

        // random part, with one full drain partway through
        for (int k = 0; k < 1000; k++)
        begin
            if (k == 500)
            begin
                // hold off until every result has arrived
                idle_cycles(1);
                while (sb.pending.size() != 0)
                    @(posedge clk);
            end
            r = make_req(2'($urandom_range(0, 3)), pick_comp(), pick_comp(), pick_comp(),
                         pick_comp(), pick_comp(), pick_comp());
            if ($urandom_range(0, 29) == 0)
                r.dir_x = 0;
            if ($urandom_range(0, 29) == 0)
            begin
                r.dir_x = 0; r.dir_y = 0; r.dir_z = 0;
            end
            send_random(r);
        end

        idle_cycles(1);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
rtl/core/v3pr_pkg.sv
rtl/core/v3pr_prod_lane.sv
rtl/core/v3pr_div_lane.sv
rtl/core/vector3_project_reflect_unit.sv
sim/tb_top.sv
